[rtl/steering_agent_step_defines.svh]
// Assertion macros for the steering agent block.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef STEERING_AGENT_STEP_DEFINES_SVH
`define STEERING_AGENT_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define SAS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define SAS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SAS_ASSERT(lbl, cond, msg)
`define SAS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/sas_pkg.sv]
// Shared types, constants and helpers of the steering agent block.
// No dependencies.
`default_nettype none
package sas_pkg;
    localparam int QW    = 24;   // Q15.8 state word
    localparam int VW    = 26;   // working vector component
    localparam int SQW   = 50;   // squared length
    localparam int PW    = 49;   // multiplier result kept
    localparam int LW    = 25;   // vector length
    localparam int SW    = 16;   // speed / force magnitude
    localparam int RW    = 23;   // radius registers
    localparam int CIW   = 3;    // config index
    localparam int CDW   = 23;   // config data
    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 49;

    localparam logic [SW-1:0] RST_MAX_SPEED = 16'd5120;
    localparam logic [SW-1:0] RST_MAX_FORCE = 16'd512;
    localparam logic [RW-1:0] RST_ARRIVE_RAD = 23'd25600;
    localparam logic [RW-1:0] RST_SEEK_RAD   = 23'd102400;
    localparam logic [RW-1:0] RST_FLEE_RAD   = 23'd102400;

    localparam logic signed [QW+2:0] SAT_HI = 27'sd8388607;
    localparam logic signed [QW+2:0] SAT_LO = -27'sd8388608;

    typedef enum logic [CIW-1:0] {
        CFG_MAX_SPEED   = 3'd0,
        CFG_MAX_FORCE   = 3'd1,
        CFG_ARRIVE_RAD  = 3'd2,
        CFG_SEEK_RAD    = 3'd3,
        CFG_FLEE_RAD    = 3'd4,
        CFG_SEEK_EN     = 3'd5,
        CFG_FLEE_EN     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_ARRIVE = 2'd0,
        PH_SEEK   = 2'd1,
        PH_FLEE   = 2'd2
    } t_phase;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIFF, OP_MULX, OP_MULY, OP_SUM, OP_SQRT_GO,
        OP_LEN_TAKE, OP_SPD_MAX, OP_SPD_FORCE, OP_SPD_MUL, OP_DIV_SPD,
        OP_SPD_TAKE, OP_MAGX_MUL, OP_MAGY_MUL, OP_DIV_LEN, OP_MAGX_TAKE,
        OP_MAGY_TAKE, OP_NEG, OP_STEER, OP_ACC, OP_UPDATE, OP_PUBLISH
    } t_op;

    typedef struct packed {
        t_op    op;
        t_phase phase;
        logic   capture;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic sqrt_busy;
        logic div_done;
        logic div_busy;
        logic len_zero;
        logic len_lt_arrive;
        logic len_ge_seek;
        logic len_ge_flee;
        logic sq_gt_limit;
        logic seek_en;
        logic flee_en;
    } t_status;

    function automatic logic signed [QW-1:0] sat24(input logic signed [QW+2:0] v);
        if (v > SAT_HI) return SAT_HI[QW-1:0];
        if (v < SAT_LO) return SAT_LO[QW-1:0];
        return v[QW-1:0];
    endfunction
endpackage
`default_nettype wire

[rtl/sas_sqrt.sv]
// Bit-serial integer square root, floor(sqrt(x)), one root bit per cycle.
// Depends on sas_pkg.
`default_nettype none
module sas_sqrt (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [sas_pkg::SQW-1:0]  i_rad,
    output logic      [sas_pkg::LW-1:0]   o_root,
    output logic                          o_busy,
    output logic                          o_done
);
    import sas_pkg::*;

    logic [SQW-1:0] r_rad;
    logic [LW:0]    r_rem;
    logic [LW-1:0]  r_root;
    logic [4:0]     r_cnt;
    logic           r_busy, r_done;
    logic [LW+2:0]  w_rem2, w_trial, w_diff;
    logic           w_ge;

    assign w_rem2  = {r_rem, r_rad[SQW-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_rem2 >= w_trial;
    assign w_diff  = w_rem2 - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(SQRT_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SQW-3:0], 2'b00};
            if (w_ge) begin
                r_rem  <= w_diff[LW:0];
                r_root <= {r_root[LW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2[LW:0];
                r_root <= {r_root[LW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/sas_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sas_pkg. Callers guarantee the quotient fits in SW bits.
`default_nettype none
module sas_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [sas_pkg::PW-1:0]  i_dividend,
    input  wire logic [sas_pkg::LW-1:0]  i_divisor,
    output logic      [sas_pkg::SW-1:0]  o_quo,
    output logic                         o_busy,
    output logic                         o_done
);
    import sas_pkg::*;

    logic [PW-1:0] r_q;
    logic [LW-1:0] r_rem, r_d;
    logic [5:0]    r_cnt;
    logic          r_busy, r_done;
    logic [LW:0]   w_rem2, w_diff;
    logic          w_ge;

    assign w_rem2 = {r_rem, r_q[PW-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_d};
    assign w_diff = w_rem2 - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[LW-1:0];
                r_q   <= {r_q[PW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2[LW-1:0];
                r_q   <= {r_q[PW-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_q[SW-1:0];
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/sas_dp.sv]
// Datapath: config registers, agent state, working vector, shared
// multiplier, square root and divider. Depends on sas_pkg, sas_sqrt, sas_div.
`default_nettype none
module sas_dp (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [sas_pkg::CIW-1:0] i_cfg_index,
    input  wire logic [sas_pkg::CDW-1:0] i_cfg_data,
    input  wire logic [191:0]            i_tdata,
    input  wire sas_pkg::t_cmd           i_cmd,
    output sas_pkg::t_status             o_st,
    output logic      [95:0]             o_tdata
);
    import sas_pkg::*;

    logic [SW-1:0] r_max_speed, r_max_force, r_spd;
    logic [RW-1:0] r_arrive_rad, r_seek_rad, r_flee_rad;
    logic          r_seek_en, r_flee_en;

    logic signed [QW-1:0] r_tx, r_ty, r_ox, r_oy, r_skx, r_sky, r_flx, r_fly;
    logic signed [QW-1:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_acc_x, r_acc_y;
    logic signed [QW-1:0] r_out_px, r_out_py, r_out_vx, r_out_vy;
    logic signed [VW-1:0] r_vx, r_vy;
    logic [PW-1:0]        r_prod;
    logic [SQW-1:0]       r_sq;
    logic [LW-1:0]        r_len;

    logic signed [QW-1:0] w_pt_x, w_pt_y;
    logic signed [VW-1:0] w_ma, w_mb, w_abs_x, w_abs_y, w_q;
    logic signed [51:0]   w_prod;
    logic [31:0]          w_mf_sq;
    logic [LW-1:0]        w_root, w_divisor;
    logic [SW-1:0]        w_quo;
    logic                 w_sqrt_busy, w_sqrt_done, w_div_busy, w_div_done;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= RST_MAX_SPEED;
            r_max_force  <= RST_MAX_FORCE;
            r_arrive_rad <= RST_ARRIVE_RAD;
            r_seek_rad   <= RST_SEEK_RAD;
            r_flee_rad   <= RST_FLEE_RAD;
            r_seek_en    <= 1'b0;
            r_flee_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data[SW-1:0];
                CFG_MAX_FORCE:  r_max_force  <= i_cfg_data[SW-1:0];
                CFG_ARRIVE_RAD: r_arrive_rad <= i_cfg_data[RW-1:0];
                CFG_SEEK_RAD:   r_seek_rad   <= i_cfg_data[RW-1:0];
                CFG_FLEE_RAD:   r_flee_rad   <= i_cfg_data[RW-1:0];
                CFG_SEEK_EN:    r_seek_en    <= i_cfg_data[0];
                CFG_FLEE_EN:    r_flee_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // point of the current force
    always_comb begin
        unique case (i_cmd.phase)
            PH_SEEK: begin
                w_pt_x = r_skx;
                w_pt_y = r_sky;
            end
            PH_FLEE: begin
                w_pt_x = r_flx;
                w_pt_y = r_fly;
            end
            default: begin
                w_pt_x = sat24(27'(r_tx) + 27'(r_ox));
                w_pt_y = sat24(27'(r_ty) + 27'(r_oy));
            end
        endcase
    end

    assign w_abs_x = r_vx[VW-1] ? -r_vx : r_vx;
    assign w_abs_y = r_vy[VW-1] ? -r_vy : r_vy;

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.op)
            OP_MULX: begin
                w_ma = r_vx;
                w_mb = r_vx;
            end
            OP_MULY: begin
                w_ma = r_vy;
                w_mb = r_vy;
            end
            OP_SPD_MUL: begin
                w_ma = VW'(r_len);
                w_mb = VW'(r_max_speed);
            end
            OP_MAGX_MUL: begin
                w_ma = w_abs_x;
                w_mb = VW'(r_spd);
            end
            default: begin
                w_ma = w_abs_y;
                w_mb = VW'(r_spd);
            end
        endcase
    end

    assign w_prod    = 52'(w_ma) * 52'(w_mb);
    assign w_mf_sq   = 32'(r_max_force) * 32'(r_max_force);
    assign w_divisor = (i_cmd.op == OP_DIV_SPD) ? LW'(r_arrive_rad) : r_len;
    assign w_q       = VW'(w_quo);

    sas_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT_GO),
        .i_rad   (r_sq),
        .o_root  (w_root),
        .o_busy  (w_sqrt_busy),
        .o_done  (w_sqrt_done)
    );

    sas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_SPD || i_cmd.op == OP_DIV_LEN),
        .i_dividend (r_prod),
        .i_divisor  (w_divisor),
        .o_quo      (w_quo),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done)
    );

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tx  <= i_tdata[23:0];
            r_ty  <= i_tdata[47:24];
            r_ox  <= i_tdata[71:48];
            r_oy  <= i_tdata[95:72];
            r_skx <= i_tdata[119:96];
            r_sky <= i_tdata[143:120];
            r_flx <= i_tdata[167:144];
            r_fly <= i_tdata[191:168];
        end
    end

    // agent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_pos_x <= r_tx;
                    r_pos_y <= r_ty;
                    r_vel_x <= r_ox;
                    r_vel_y <= r_oy;
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                end
                OP_ACC: begin
                    r_acc_x <= sat24(27'(r_acc_x) + 27'(r_vx));
                    r_acc_y <= sat24(27'(r_acc_y) + 27'(r_vy));
                end
                OP_UPDATE: begin
                    r_pos_x <= sat24(27'(r_pos_x) + 27'(r_vel_x));
                    r_pos_y <= sat24(27'(r_pos_y) + 27'(r_vel_y));
                    r_vel_x <= sat24(27'(r_vel_x) + 27'(r_acc_x));
                    r_vel_y <= sat24(27'(r_vel_y) + 27'(r_acc_y));
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_DIFF: begin
                r_vx <= VW'(w_pt_x) - VW'(r_pos_x);
                r_vy <= VW'(w_pt_y) - VW'(r_pos_y);
            end
            OP_MULX, OP_SPD_MUL, OP_MAGX_MUL, OP_MAGY_MUL: r_prod <= w_prod[PW-1:0];
            OP_MULY: begin
                r_sq   <= {1'b0, r_prod};
                r_prod <= w_prod[PW-1:0];
            end
            OP_SUM:       r_sq  <= r_sq + {1'b0, r_prod};
            OP_LEN_TAKE:  r_len <= w_root;
            OP_SPD_MAX:   r_spd <= r_max_speed;
            OP_SPD_FORCE: r_spd <= r_max_force;
            OP_SPD_TAKE:  r_spd <= w_quo;
            OP_MAGX_TAKE: r_vx  <= r_vx[VW-1] ? -w_q : w_q;
            OP_MAGY_TAKE: r_vy  <= r_vy[VW-1] ? -w_q : w_q;
            OP_NEG: begin
                r_vx <= -r_vx;
                r_vy <= -r_vy;
            end
            OP_STEER: begin
                r_vx <= r_vx - VW'(r_vel_x);
                r_vy <= r_vy - VW'(r_vel_y);
            end
            OP_PUBLISH: begin
                r_out_px <= r_pos_x;
                r_out_py <= r_pos_y;
                r_out_vx <= r_vel_x;
                r_out_vy <= r_vel_y;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_st.sqrt_done     = w_sqrt_done;
        o_st.sqrt_busy     = w_sqrt_busy;
        o_st.div_done      = w_div_done;
        o_st.div_busy      = w_div_busy;
        o_st.len_zero      = (r_len == '0);
        o_st.len_lt_arrive = r_len < LW'(r_arrive_rad);
        o_st.len_ge_seek   = r_len >= LW'(r_seek_rad);
        o_st.len_ge_flee   = r_len >= LW'(r_flee_rad);
        o_st.sq_gt_limit   = r_sq > SQW'(w_mf_sq);
        o_st.seek_en       = r_seek_en;
        o_st.flee_en       = r_flee_en;
    end

    assign o_tdata = {r_out_vy, r_out_vx, r_out_py, r_out_px};
endmodule
`default_nettype wire

[rtl/sas_ctrl.sv]
// Sequencer for one item: a load, or a tick of arrive, seek and flee forces in turn, then update.
// Depends on sas_pkg; drives sas_dp through t_cmd and reads t_status.
`default_nettype none
module sas_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_load,
    input  wire logic              i_out_ready,
    input  wire sas_pkg::t_status  i_st,
    output sas_pkg::t_cmd          o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid
);
    import sas_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE      = 24'h000001, S_LOAD      = 24'h000002,
        S_DIFF      = 24'h000004, S_MULX      = 24'h000008,
        S_MULY      = 24'h000010, S_SUM       = 24'h000020,
        S_SQRT_GO   = 24'h000040, S_SQRT_WAIT = 24'h000080,
        S_DECIDE    = 24'h000100, S_SPD_MUL   = 24'h000200,
        S_SPD_GO    = 24'h000400, S_SPD_WAIT  = 24'h000800,
        S_FORCE     = 24'h001000, S_MAGX_MUL  = 24'h002000,
        S_MAGX_GO   = 24'h004000, S_MAGX_WAIT = 24'h008000,
        S_MAGY_MUL  = 24'h010000, S_MAGY_GO   = 24'h020000,
        S_MAGY_WAIT = 24'h040000, S_NEG       = 24'h080000,
        S_STEER     = 24'h100000, S_ACC       = 24'h200000,
        S_UPDATE    = 24'h400000, S_PUB       = 24'h800000
    } t_state;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_clamp, n_clamp;
    logic   r_ovalid, n_ovalid;
    t_phase w_nx_phase;
    t_state w_nx_state;

    // force that follows the current one
    always_comb begin
        w_nx_phase = r_phase;
        w_nx_state = S_UPDATE;
        unique case (r_phase)
            PH_ARRIVE: begin
                if (i_st.seek_en) begin
                    w_nx_phase = PH_SEEK;
                    w_nx_state = S_DIFF;
                end else if (i_st.flee_en) begin
                    w_nx_phase = PH_FLEE;
                    w_nx_state = S_DIFF;
                end
            end
            PH_SEEK: begin
                if (i_st.flee_en) begin
                    w_nx_phase = PH_FLEE;
                    w_nx_state = S_DIFF;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_clamp       = r_clamp;
        n_ovalid      = r_ovalid && !i_out_ready;
        o_cmd.op      = OP_NONE;
        o_cmd.phase   = r_phase;
        o_cmd.capture = 1'b0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_phase = PH_ARRIVE;
                    n_clamp = 1'b0;
                    n_state = i_in_load ? S_LOAD : S_DIFF;
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = S_PUB;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_MULX;
            end
            S_MULX: begin
                o_cmd.op = OP_MULX;
                n_state  = S_MULY;
            end
            S_MULY: begin
                o_cmd.op = OP_MULY;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_SQRT_GO;
            end
            S_SQRT_GO: begin
                // steering within the force limit skips the clamp
                if (r_clamp && !i_st.sq_gt_limit) begin
                    n_state = S_ACC;
                end else begin
                    o_cmd.op = OP_SQRT_GO;
                    n_state  = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT: begin
                if (i_st.sqrt_done) begin
                    o_cmd.op = OP_LEN_TAKE;
                    n_state  = r_clamp ? S_FORCE : S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.op = OP_SPD_MAX;
                priority if (r_phase == PH_ARRIVE) begin
                    priority if (i_st.len_zero)      n_state = S_STEER;
                    else if (i_st.len_lt_arrive)     n_state = S_SPD_MUL;
                    else                             n_state = S_MAGX_MUL;
                end else if ((r_phase == PH_SEEK && i_st.len_ge_seek) ||
                             (r_phase == PH_FLEE && i_st.len_ge_flee)) begin
                    n_phase = w_nx_phase;
                    n_state = w_nx_state;
                end else begin
                    n_state = i_st.len_zero ? S_STEER : S_MAGX_MUL;
                end
            end
            S_SPD_MUL: begin
                o_cmd.op = OP_SPD_MUL;
                n_state  = S_SPD_GO;
            end
            S_SPD_GO: begin
                o_cmd.op = OP_DIV_SPD;
                n_state  = S_SPD_WAIT;
            end
            S_SPD_WAIT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_SPD_TAKE;
                    n_state  = S_MAGX_MUL;
                end
            end
            S_FORCE: begin
                o_cmd.op = OP_SPD_FORCE;
                n_state  = S_MAGX_MUL;
            end
            S_MAGX_MUL: begin
                o_cmd.op = OP_MAGX_MUL;
                n_state  = S_MAGX_GO;
            end
            S_MAGX_GO: begin
                o_cmd.op = OP_DIV_LEN;
                n_state  = S_MAGX_WAIT;
            end
            S_MAGX_WAIT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_MAGX_TAKE;
                    n_state  = S_MAGY_MUL;
                end
            end
            S_MAGY_MUL: begin
                o_cmd.op = OP_MAGY_MUL;
                n_state  = S_MAGY_GO;
            end
            S_MAGY_GO: begin
                o_cmd.op = OP_DIV_LEN;
                n_state  = S_MAGY_WAIT;
            end
            S_MAGY_WAIT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_MAGY_TAKE;
                    priority if (r_clamp)           n_state = S_ACC;
                    else if (r_phase == PH_FLEE)    n_state = S_NEG;
                    else                            n_state = S_STEER;
                end
            end
            S_NEG: begin
                o_cmd.op = OP_NEG;
                n_state  = S_STEER;
            end
            S_STEER: begin
                o_cmd.op = OP_STEER;
                n_clamp  = 1'b1;
                n_state  = S_MULX;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_clamp  = 1'b0;
                n_phase  = w_nx_phase;
                n_state  = w_nx_state;
            end
            S_UPDATE: begin
                o_cmd.op = OP_UPDATE;
                n_state  = S_PUB;
            end
            S_PUB: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_PUBLISH;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_ARRIVE;
            r_clamp  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_clamp  <= n_clamp;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule
`default_nettype wire

[rtl/steering_agent_step.sv]
// Top level of the steering agent block: controller plus datapath.
// Depends on sas_pkg, sas_ctrl, sas_dp and steering_agent_step_defines.svh.
//
// Usage:
//  - Input stream (s_axis_*): one transfer per tick or load. tuser is the
//    operation (0 tick, 1 load); tdata carries target, offset, seek and flee
//    points. On a load, target is the new position and offset the velocity.
//  - Output stream (m_axis_*): one transfer per input, the agent's position
//    and velocity after the item.
//  - Config: i_cfg_we / i_cfg_index / i_cfg_data, written while idle.
//  - Sequencing: a load holds the sequencer for its load and publish steps
//    only. A tick runs the arrive force, then seek and flee where enabled and
//    in range, and clamps each steering force to the force limit; each vector
//    length costs a bit-serial square root and each scale a bit-serial divide.
//  - One item is in flight at a time; s_axis_tready is high only while
//    the sequencer is idle.
//  - The result sits in an output register: the next item is accepted
//    while it waits, and a stalled receiver only holds that item's
//    publish step until the register frees.
//  - Reset (synchronous, active low) clears state to zero and loads the
//    default config values.
`default_nettype none
`include "steering_agent_step_defines.svh"
module steering_agent_step (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // target_x, target_y, offset_x, offset_y, seek_x, seek_y, flee_x, flee_y
    input  wire logic [191:0]            s_axis_tdata,
    // operation
    input  wire logic [0:0]              s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // pos_x, pos_y, vel_x, vel_y
    output logic      [95:0]             m_axis_tdata,
    input  wire logic                    i_cfg_we,
    input  wire logic [sas_pkg::CIW-1:0] i_cfg_index,
    input  wire logic [sas_pkg::CDW-1:0] i_cfg_data
);
    import sas_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    sas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_load   (s_axis_tuser[0]),
        .i_out_ready (m_axis_tready),
        .i_st        (w_st),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    sas_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .o_tdata     (m_axis_tdata)
    );

    // sequencer busy right after a transfer in
    `SAS_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    // sqrt and divider are never used at once
    `SAS_ASSERT(a_one_unit, !(w_st.sqrt_busy && w_st.div_busy), "sqrt and div overlap")
    // a publish always presents a result
    `SAS_ASSERT_NEXT(a_publish_valid, w_cmd.op == OP_PUBLISH, m_axis_tvalid, "publish lost")
endmodule
`default_nettype wire
